// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, payload types and controller/datapath signal groups for the
// preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Field widths of the input and result transactions
  localparam int unsigned ARR_W   = 12;
  localparam int unsigned BURST_W = 8;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned PIDX_W  = 4;
  localparam int unsigned TIME_W  = 13;
  localparam int unsigned SUM_W   = 17;

  // Largest burst a record can carry
  localparam int unsigned BURST_MAX = 255;

  // Default process table depth
  localparam int unsigned DEF_MAX_PROCS = 16;

  // One process record
  typedef struct packed {
    logic [ARR_W-1:0]   arrival_time;
    logic [BURST_W-1:0] burst_time;
    logic [PRI_W-1:0]   priority_req;
    logic               last_process;
  } in_item_t;

  // One per-process result
  typedef struct packed {
    logic [PIDX_W-1:0] proc_index;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic              overflow;
    logic              last_result;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // store the accepted record
    logic scan_clear;   // restart the per-tick scan
    logic scan_issue;   // read the next table entry for the scan
    logic tick_commit;  // run the winner for one tick, advance time
    logic out_start;    // rewind the index and clear the running sums
    logic out_calc;     // form turnaround and waiting time of the entry
    logic out_latch;    // load the result register
    logic out_next;     // step to the next entry
    logic run_clear;    // drop the batch, ready for the next one
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_last;     // index points at the last loaded entry
    logic all_done;     // every loaded process has finished
  } dp_stat_t;

endpackage : pps_pkg

`default_nettype wire

// ===== src/pps_in_if.sv =====
// ----------------------------------------------------------------------------
// pps_in_if
// Valid/ready channel that carries one process record per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_in_if;
  import pps_pkg::*;

  logic               valid;
  logic               ready;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic [PRI_W-1:0]   priority_req;
  logic               last_process;

  modport source (
    output valid, arrival_time, burst_time, priority_req, last_process,
    input  ready
  );

  modport sink (
    input  valid, arrival_time, burst_time, priority_req, last_process,
    output ready
  );

endinterface : pps_in_if

`default_nettype wire

// ===== src/pps_out_if.sv =====
// ----------------------------------------------------------------------------
// pps_out_if
// Valid/ready channel that carries one per-process result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_out_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] proc_index;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [SUM_W-1:0]  total_waiting;
  logic [SUM_W-1:0]  total_turnaround;
  logic              overflow;
  logic              last_result;

  modport source (
    output valid, proc_index, completion_time, waiting_time, turnaround_time,
           total_waiting, total_turnaround, overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, proc_index, completion_time, waiting_time, turnaround_time,
           total_waiting, total_turnaround, overflow, last_result,
    output ready
  );

endinterface : pps_out_if

`default_nettype wire

// ===== src/priority_preemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler
// Preemptive priority scheduler: loads process records, simulates unit ticks
// and reports completion, waiting and turnaround time per process.
// ----------------------------------------------------------------------------
// Records are taken one per cycle on in_chan until the one flagged
// last_process; records past MAX_PROCS are dropped and reported through the
// overflow bit. The block then simulates the schedule one tick at a time: each
// tick scans the process table through a single registered read port, one entry
// per cycle, then drains the last read and commits the winner, for every tick
// up to the last completion (idle ticks included). Results leave on out_chan
// in load order, each read, formed and latched, then held until taken; the
// final one flagged last_result; no new record is taken until it is accepted.
`default_nettype none

module priority_preemptive_scheduler #(
  parameter int unsigned MAX_PROCS = pps_pkg::DEF_MAX_PROCS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pps_in_if.sink    in_chan,
  pps_out_if.source out_chan
);
  import pps_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int unsigned TICK_W = $clog2((2 ** ARR_W) + MAX_PROCS * BURST_MAX + 1);

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  // Gather the record fields
  assign in_item.arrival_time = in_chan.arrival_time;
  assign in_item.burst_time   = in_chan.burst_time;
  assign in_item.priority_req = in_chan.priority_req;
  assign in_item.last_process = in_chan.last_process;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_process),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pps_dp #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .TICK_W    (TICK_W)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  // Drive the result fields
  assign out_chan.proc_index       = out_item.proc_index;
  assign out_chan.completion_time  = out_item.completion_time;
  assign out_chan.waiting_time     = out_item.waiting_time;
  assign out_chan.turnaround_time  = out_item.turnaround_time;
  assign out_chan.total_waiting    = out_item.total_waiting;
  assign out_chan.total_turnaround = out_item.total_turnaround;
  assign out_chan.overflow         = out_item.overflow;
  assign out_chan.last_result      = out_item.last_result;

endmodule : priority_preemptive_scheduler

`default_nettype wire

// ===== src/pps_dp.sv =====
// ----------------------------------------------------------------------------
// pps_dp
// Scheduler datapath: process table memories, tick counter, per-tick
// highest-priority scan and result arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_dp #(
  parameter int unsigned MAX_PROCS = pps_pkg::DEF_MAX_PROCS,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned TICK_W    = 13
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pps_pkg::in_item_t  in_item,
  input  wire pps_pkg::dp_cmd_t   cmd,
  output pps_pkg::dp_stat_t       stat,
  output pps_pkg::out_item_t      out_item
);
  import pps_pkg::*;

  // Process table; completion ticks keep the full tick width so that the
  // running sums see untruncated times
  logic [ARR_W-1:0]   arrival_mem [MAX_PROCS];
  logic [BURST_W-1:0] burst_mem   [MAX_PROCS];
  logic [BURST_W-1:0] rem_mem     [MAX_PROCS];
  logic [PRI_W-1:0]   pri_mem     [MAX_PROCS];
  logic [TICK_W-1:0]  comp_mem    [MAX_PROCS];

  // Control state
  logic [CNT_W-1:0]  loaded_r,   loaded_nxt;
  logic [CNT_W-1:0]  finished_r, finished_nxt;
  logic [TICK_W-1:0] tick_r,     tick_nxt;
  logic              dropped_r,  dropped_nxt;
  logic [IDX_W-1:0]  idx_r,      idx_nxt;
  logic              rd_vld_r;
  logic              found_r,    found_nxt;

  // Payload registers
  logic [IDX_W-1:0]   rd_idx_r;
  logic [ARR_W-1:0]   rd_arr_r;
  logic [BURST_W-1:0] rd_bur_r;
  logic [BURST_W-1:0] rd_rem_r;
  logic [PRI_W-1:0]   rd_pri_r;
  logic [TICK_W-1:0]  rd_cmp_r;
  logic [IDX_W-1:0]   pick_r;
  logic [PRI_W-1:0]   best_r;
  logic [BURST_W-1:0] pick_rem_r;
  logic [TICK_W-1:0]  turn_r;
  logic [TICK_W-1:0]  wait_r;
  logic [SUM_W-1:0]   sum_wait_r;
  logic [SUM_W-1:0]   sum_turn_r;
  out_item_t          out_item_r;

  logic               full;
  logic               cand;
  logic [BURST_W-1:0] load_burst;
  logic [IDX_W-1:0]   load_idx;
  logic [SUM_W-1:0]   sum_wait_add;
  logic [SUM_W-1:0]   sum_turn_add;

  assign full       = (loaded_r == CNT_W'(MAX_PROCS));
  assign load_idx   = loaded_r[IDX_W-1:0];
  assign load_burst = (in_item.burst_time == '0) ? BURST_W'(1) : in_item.burst_time;

  // Entry read last cycle is ready, has work and beats the best so far
  assign cand = rd_vld_r && (TICK_W'(rd_arr_r) <= tick_r) && (rd_rem_r != '0) &&
                (!found_r || (rd_pri_r > best_r));

  assign stat.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == loaded_r);
  assign stat.all_done = (finished_r == loaded_r);

  assign sum_wait_add = sum_wait_r + SUM_W'(wait_r);
  assign sum_turn_add = sum_turn_r + SUM_W'(turn_r);

  // Next state of the counters and scan control
  always_comb begin
    loaded_nxt   = loaded_r;
    finished_nxt = finished_r;
    tick_nxt     = tick_r;
    dropped_nxt  = dropped_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r || cand;

    if (cmd.load) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        loaded_nxt = loaded_r + CNT_W'(1);
      end
    end
    if (cmd.scan_clear || cmd.out_start) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.scan_issue || cmd.out_next) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.tick_commit) begin
      tick_nxt = tick_r + TICK_W'(1);
      if (found_r && (pick_rem_r == BURST_W'(1))) begin
        finished_nxt = finished_r + CNT_W'(1);
      end
    end
    if (cmd.run_clear) begin
      loaded_nxt   = '0;
      finished_nxt = '0;
      tick_nxt     = '0;
      dropped_nxt  = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r   <= '0;
      finished_r <= '0;
      tick_r     <= '0;
      dropped_r  <= 1'b0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      loaded_r   <= loaded_nxt;
      finished_r <= finished_nxt;
      tick_r     <= tick_nxt;
      dropped_r  <= dropped_nxt;
      idx_r      <= idx_nxt;
      rd_vld_r   <= cmd.scan_issue;
      found_r    <= found_nxt;
    end
  end

  // Write the table: records on load, remaining work and completion on commit
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      arrival_mem[load_idx] <= in_item.arrival_time;
      burst_mem[load_idx]   <= load_burst;
      rem_mem[load_idx]     <= load_burst;
      pri_mem[load_idx]     <= in_item.priority_req;
    end
    if (cmd.tick_commit && found_r) begin
      rem_mem[pick_r] <= pick_rem_r - BURST_W'(1);
      if (pick_rem_r == BURST_W'(1)) begin
        comp_mem[pick_r] <= tick_r + TICK_W'(1);
      end
    end
  end

  // Read the table at the current index
  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    rd_arr_r <= arrival_mem[idx_r];
    rd_bur_r <= burst_mem[idx_r];
    rd_rem_r <= rem_mem[idx_r];
    rd_pri_r <= pri_mem[idx_r];
    rd_cmp_r <= comp_mem[idx_r];
  end

  // Track the scan winner
  always_ff @(posedge clk) begin
    if (cand) begin
      pick_r     <= rd_idx_r;
      best_r     <= rd_pri_r;
      pick_rem_r <= rd_rem_r;
    end
  end

  // Form times and running sums of one result
  always_ff @(posedge clk) begin
    if (cmd.out_start) begin
      sum_wait_r <= '0;
      sum_turn_r <= '0;
    end
    if (cmd.out_calc) begin
      turn_r <= rd_cmp_r - TICK_W'(rd_arr_r);
      wait_r <= rd_cmp_r - TICK_W'(rd_arr_r) - TICK_W'(rd_bur_r);
    end
    if (cmd.out_latch) begin
      sum_wait_r                  <= sum_wait_add;
      sum_turn_r                  <= sum_turn_add;
      out_item_r.proc_index       <= PIDX_W'(idx_r);
      out_item_r.completion_time  <= TIME_W'(rd_cmp_r);
      out_item_r.waiting_time     <= TIME_W'(wait_r);
      out_item_r.turnaround_time  <= TIME_W'(turn_r);
      out_item_r.total_waiting    <= sum_wait_add;
      out_item_r.total_turnaround <= sum_turn_add;
      out_item_r.overflow         <= dropped_r;
      out_item_r.last_result      <= stat.idx_last;
    end
  end

  assign out_item = out_item_r;

`ifndef SYNTHESIS
  a_finished_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r <= loaded_r)
    else $error("finished count exceeds loaded count");

  a_loaded_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_PROCS))
    else $error("loaded count exceeds table depth");

  a_winner_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick_commit && found_r) |-> (pick_rem_r != '0))
    else $error("scan winner has no remaining work");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !full && !dropped_r) |=> !dropped_r)
    else $error("record dropped while table had room");
`endif

endmodule : pps_dp

`default_nettype wire

// ===== src/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Scheduler controller: load phase, per-tick scan sequencing and result
// delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pps_pkg::dp_stat_t stat,
  output pps_pkg::dp_cmd_t       cmd
);
  import pps_pkg::*;

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_DRAIN     = 4'd3;
  localparam logic [3:0] S_TICK      = 4'd4;
  localparam logic [3:0] S_OUT_RD    = 4'd5;
  localparam logic [3:0] S_OUT_CALC  = 4'd6;
  localparam logic [3:0] S_OUT_LATCH = 4'd7;
  localparam logic [3:0] S_OUT_WAIT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT_WAIT);

  // Sequence the phases and issue datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.all_done) begin
          cmd.out_start = 1'b1;
          state_nxt     = S_OUT_RD;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_TICK;
      end
      S_TICK: begin
        cmd.tick_commit = 1'b1;
        state_nxt       = S_CHECK;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_CALC;
      end
      S_OUT_CALC: begin
        cmd.out_calc = 1'b1;
        state_nxt    = S_OUT_LATCH;
      end
      S_OUT_LATCH: begin
        cmd.out_latch = 1'b1;
        state_nxt     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          if (stat.idx_last) begin
            cmd.run_clear = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_side_active: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading and delivering at the same time");

  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (state_r == S_CHECK))
    else $error("last record did not start the run");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");
`endif

endmodule : pps_ctrl

`default_nettype wire
